// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Depends on nothing; clock and reset are passed in by the user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define ASSERT_IMPL(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Condition implies consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/mrt_pkg.sv =====
// Shared constants, types and state encoding for the Miller-Rabin test.
// No dependencies.
`default_nettype none

package mrt_pkg;

  localparam int FIELD_W    = 64;                 // port width of the input fields
  localparam int WORD_WIDTH = 64;                 // arithmetic width, 8..64
  localparam int W          = WORD_WIDTH;
  localparam int CNT_W      = $clog2(W);

  localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_REDUCE,
    ST_MUL,
    ST_SQ,
    ST_CHECK,
    ST_LOOP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

`default_nettype wire

// ===== sv/mrt_mulmod.sv =====
// Iterative modular multiplier: result = (x * y) mod n, one bit of y per cycle.
// Needs x < n, n >= 2; y may be any value. Depends on mrt_pkg.
`default_nettype none

module mrt_mulmod (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [mrt_pkg::W-1:0] x,
  input  wire logic [mrt_pkg::W-1:0] y,
  input  wire logic [mrt_pkg::W-1:0] n,
  output logic      [mrt_pkg::W-1:0] result,
  output mrt_pkg::mm_stat_t        stat
);
  import mrt_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     acc;
  logic [W-1:0]     acc_next;
  logic [W-1:0]     x_q;
  logic [W-1:0]     y_q;
  logic [W-1:0]     n_q;
  logic [W+1:0]     t;
  logic [W+1:0]     n1;
  logic [W+1:0]     n2;

  // acc < n and addend < n, so t < 3n: at most two subtractions of n
  always_comb begin
    n1 = {2'b00, n_q};
    n2 = {1'b0, n_q, 1'b0};
    t  = {1'b0, acc, 1'b0} + (y_q[W-1] ? {2'b00, x_q} : '0);
    if (t >= n2) begin
      acc_next = W'(t - n2);
    end else if (t >= n1) begin
      acc_next = W'(t - n1);
    end else begin
      acc_next = W'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      x_q <= x;
      y_q <= y;
      n_q <= n;
    end else if (busy) begin
      acc <= acc_next;
      y_q <= {y_q[W-2:0], 1'b0};
    end
  end

  assign result    = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

// ===== sv/miller_rabin_single_base_test.sv =====
// Miller-Rabin strong probable prime test for one base, top level.
// Depends on mrt_pkg, mrt_mulmod and assert_macros.svh.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid, in_stall, witness_base, | into block
//           | candidate                        |
//   out     | out_valid, out_stall,            | out of block
//           | probable_prime, input_valid      |
//
// Each modular product runs in the shared bit-serial multiplier; a test spends
// its time in those products, plus stripping factors of two, the final check
// and the result item. A candidate below two skips the test and goes straight
// to the result item. in_stall is high from accept until the result item is
// taken; rst is synchronous and returns to idle.
`default_nettype none

`include "assert_macros.svh"

module miller_rabin_single_base_test (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [mrt_pkg::FIELD_W-1:0] witness_base,
  input  wire logic [mrt_pkg::FIELD_W-1:0] candidate,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            probable_prime,
  output logic                            input_valid
);
  import mrt_pkg::*;

  state_t           state, state_next;
  logic [W-1:0]     n_q, n_q_next;
  logic [W-1:0]     nm1_q, nm1_q_next;
  logic [W-1:0]     d_q, d_q_next;
  logic [CNT_W-1:0] s_q, s_q_next;
  logic [W-1:0]     a_q, a_q_next;
  logic [W-1:0]     r_q, r_q_next;
  logic [W-1:0]     base_q, base_q_next;
  logic             prime_q, prime_q_next;
  logic             inval_q, inval_q_next;

  logic             mm_start;
  logic [W-1:0]     mm_x;
  logic [W-1:0]     mm_y;
  logic [W-1:0]     mm_res;
  mm_stat_t         mm_stat;
  logic [W-1:0]     in_base;
  logic [W-1:0]     in_n;

  assign in_base = witness_base[W-1:0];
  assign in_n    = candidate[W-1:0];

  mrt_mulmod u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .x      (mm_x),
    .y      (mm_y),
    .n      (n_q),
    .result (mm_res),
    .stat   (mm_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    n_q     <= n_q_next;
    nm1_q   <= nm1_q_next;
    d_q     <= d_q_next;
    s_q     <= s_q_next;
    a_q     <= a_q_next;
    r_q     <= r_q_next;
    base_q  <= base_q_next;
    prime_q <= prime_q_next;
    inval_q <= inval_q_next;
  end

  always_comb begin
    state_next   = state;
    n_q_next     = n_q;
    nm1_q_next   = nm1_q;
    d_q_next     = d_q;
    s_q_next     = s_q;
    a_q_next     = a_q;
    r_q_next     = r_q;
    base_q_next  = base_q;
    prime_q_next = prime_q;
    inval_q_next = inval_q;
    mm_start     = 1'b0;
    mm_x         = a_q;
    mm_y         = a_q;
    in_stall     = 1'b1;
    out_valid    = 1'b0;

    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          n_q_next     = in_n;
          nm1_q_next   = in_n - 1'b1;
          d_q_next     = in_n - 1'b1;
          s_q_next     = '0;
          r_q_next     = ONE;
          base_q_next  = in_base;
          prime_q_next = 1'b0;
          if (in_n[W-1:1] == '0) begin
            inval_q_next = 1'b0;
            state_next   = ST_DONE;
          end else begin
            inval_q_next = 1'b1;
            state_next   = ST_SPLIT;
          end
        end
      end

      ST_SPLIT: begin
        if (!d_q[0]) begin
          d_q_next = {1'b0, d_q[W-1:1]};
          s_q_next = s_q + 1'b1;
        end else begin
          // base mod n as 1 * base mod n
          mm_start   = 1'b1;
          mm_x       = ONE;
          mm_y       = base_q;
          state_next = ST_REDUCE;
        end
      end

      ST_REDUCE: begin
        if (mm_stat.done) begin
          a_q_next = mm_res;
          mm_start = 1'b1;
          if (d_q[0]) begin
            mm_x       = r_q;
            mm_y       = mm_res;
            state_next = ST_MUL;
          end else begin
            mm_x       = mm_res;
            mm_y       = mm_res;
            state_next = ST_SQ;
          end
        end
      end

      ST_MUL: begin
        if (mm_stat.done) begin
          r_q_next = mm_res;
          if (d_q[W-1:1] == '0) begin
            state_next = ST_CHECK;
          end else begin
            mm_start   = 1'b1;
            mm_x       = a_q;
            mm_y       = a_q;
            state_next = ST_SQ;
          end
        end
      end

      ST_SQ: begin
        if (mm_stat.done) begin
          a_q_next = mm_res;
          d_q_next = {1'b0, d_q[W-1:1]};
          mm_start = 1'b1;
          if (d_q[1]) begin
            mm_x       = r_q;
            mm_y       = mm_res;
            state_next = ST_MUL;
          end else begin
            mm_x       = mm_res;
            mm_y       = mm_res;
          end
        end
      end

      ST_CHECK: begin
        if (r_q == ONE || r_q == nm1_q) begin
          prime_q_next = 1'b1;
          state_next   = ST_DONE;
        end else if (s_q > CNT_W'(1)) begin
          s_q_next   = s_q - 1'b1;
          mm_start   = 1'b1;
          mm_x       = r_q;
          mm_y       = r_q;
          state_next = ST_LOOP;
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_LOOP: begin
        if (mm_stat.done) begin
          r_q_next = mm_res;
          if (mm_res == ONE) begin
            state_next = ST_DONE;
          end else if (mm_res == nm1_q) begin
            prime_q_next = 1'b1;
            state_next   = ST_DONE;
          end else if (s_q > CNT_W'(1)) begin
            s_q_next = s_q - 1'b1;
            mm_start = 1'b1;
            mm_x     = mm_res;
            mm_y     = mm_res;
          end else begin
            state_next = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign probable_prime = prime_q;
  assign input_valid    = inval_q;

  `ASSERT_IMPL(a_out_blocks_in, clk, rst, out_valid, in_stall)
  `ASSERT_IMPL(a_prime_needs_valid, clk, rst, out_valid && probable_prime, input_valid)
  `ASSERT_IMPL(a_start_when_free, clk, rst, mm_start, !mm_stat.busy)
  `ASSERT_NEXT(a_accept_no_result, clk, rst, in_valid && !in_stall, !mm_stat.busy)

endmodule

`default_nettype wire
